// ===== rtl/rcpa_pkg.sv =====
// Shared constants and types of the reference-counted page allocator.
`default_nettype none

package rcpa_pkg;

    // Default sizing
    localparam int RCPA_NUM_PAGES   = 16384;
    localparam int RCPA_COUNT_WIDTH = 16;

    // Fixed field widths
    localparam int FUNC_W   = 3;
    localparam int PAGE_W   = 14;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 16;
    localparam int FREE_W   = 15;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_ADD     = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_QUERY   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DONATE  = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_ZERO  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_SAT   = 3'd4;

    // Register index (word index, taken from paddr[2])
    localparam logic REG_LOWEST_PAGE = 1'b0;

    typedef enum logic
    {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/rcpa_stack_mem.sv =====
// Free page stack: single-port-write, single-read synchronous RAM.
`default_nettype none

module rcpa_stack_mem
    import rcpa_pkg::*;
#(
    parameter int DEPTH  = RCPA_NUM_PAGES,
    parameter int ADDR_W = $clog2(RCPA_NUM_PAGES)
)
(
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [PAGE_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [PAGE_W-1:0] wr_data
);

    logic [PAGE_W-1:0] mem [DEPTH];
    logic [PAGE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/rcpa_count_mem.sv =====
// Reference count RAM with a zero-fill sweep after reset.
`default_nettype none

module rcpa_count_mem
    import rcpa_pkg::*;
#(
    parameter int DEPTH  = RCPA_NUM_PAGES,
    parameter int ADDR_W = $clog2(RCPA_NUM_PAGES),
    parameter int DATA_W = RCPA_COUNT_WIDTH
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    output logic                   clear_busy,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic              clear_busy_reg;
    logic              clear_busy_next;
    logic [ADDR_W-1:0] clear_idx_reg;
    logic [ADDR_W-1:0] clear_idx_next;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;

    // Sweep one entry per cycle until the last one is zeroed
    always_comb
    begin
        clear_busy_next = clear_busy_reg;
        clear_idx_next  = clear_idx_reg;
        if (clear_busy_reg)
        begin
            clear_idx_next = clear_idx_reg + ADDR_W'(1);
            if (clear_idx_reg == ADDR_W'(DEPTH - 1))
            begin
                clear_busy_next = 1'b0;
            end
        end
        mem_we    = clear_busy_reg | wr_en;
        mem_waddr = clear_busy_reg ? clear_idx_reg : wr_addr;
        mem_wdata = clear_busy_reg ? '0 : wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_idx_reg  <= '0;
        end
        else
        begin
            clear_busy_reg <= clear_busy_next;
            clear_idx_reg  <= clear_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data    = rd_data_reg;
    assign clear_busy = clear_busy_reg;

endmodule

`default_nettype wire

// ===== rtl/refcounted_page_allocator_core.sv =====
// Top level of the reference-counted page allocator.
//
// Request channel (in_valid/in_ready) carries one word: func and page.
// Response channel (out_valid/out_ready) returns one word per request:
// status, alloc_page, ref_count, page_freed and free_pages.
// Config: APB write of lowest_page at byte address 0; pready is tied high.
//
// Timing: a request accepted at an edge reads the count RAM and the stack RAM
// at that edge; once the registered read data is back, the result is written
// back and registered at the first edge at which the output register is free,
// and out_valid rises with it. The next request is taken in the cycle after
// that, so no new word is accepted before the last one has executed: the
// read-modify-write runs through the registered reads of the two RAMs.
// Stall: a result waiting in the output register does not block the next
// accept; the execute state of that next request holds until the output
// register is free, and in_ready stays low meanwhile.
// Reset: free stack empty, lowest_page 0, then the count RAM is swept to
// zero one entry a cycle over all NUM_PAGES entries (16384 by default) with
// in_ready low; config writes are taken during the sweep.
`default_nettype none

module refcounted_page_allocator_core
    import rcpa_pkg::*;
#(
    parameter int NUM_PAGES   = RCPA_NUM_PAGES,
    parameter int COUNT_WIDTH = RCPA_COUNT_WIDTH
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // request
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [FUNC_W-1:0]   func,
    input  wire logic [PAGE_W-1:0]   page,
    // response
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic      [STATUS_W-1:0] status,
    output logic      [PAGE_W-1:0]   alloc_page,
    output logic      [COUNT_W-1:0]  ref_count,
    output logic                     page_freed,
    output logic      [FREE_W-1:0]   free_pages,
    // APB config
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic      [PDATA_W-1:0]  prdata,
    output logic                     pready
);

    localparam int IDX_W = $clog2(NUM_PAGES);
    localparam int TOP_W = $clog2(NUM_PAGES + 1);

    state_t                  state_reg, state_next;
    logic [FUNC_W-1:0]       func_reg;
    logic [PAGE_W-1:0]       page_reg;
    logic [TOP_W-1:0]        top_reg, top_next;
    logic [PAGE_W-1:0]       lowest_page_reg;

    logic                    out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [PAGE_W-1:0]       alloc_page_reg, alloc_page_next;
    logic [COUNT_W-1:0]      ref_count_reg, ref_count_next;
    logic                    page_freed_reg, page_freed_next;
    logic [FREE_W-1:0]       free_pages_reg, free_pages_next;

    logic                    accept;
    logic                    clear_busy;
    logic                    stk_wr_en;
    logic [PAGE_W-1:0]       stk_rd_data;
    logic                    cnt_wr_en;
    logic [IDX_W-1:0]        cnt_wr_addr;
    logic [COUNT_WIDTH-1:0]  cnt_wr_data;
    logic [COUNT_WIDTH-1:0]  cnt_rd_data;

    assign in_ready = (state_reg == ST_IDLE) && !clear_busy;
    assign accept   = in_valid && in_ready;

    // ---- APB register ----
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LOWEST_PAGE) ? PDATA_W'(lowest_page_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_page_reg <= '0;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_LOWEST_PAGE))
        begin
            lowest_page_reg <= pwdata[PAGE_W-1:0];
        end
    end

    // ---- memories ----
    // Stack read at accept targets the current top entry (used by allocate);
    // a push writes at the top during the execute state.
    rcpa_stack_mem #(
        .DEPTH  (NUM_PAGES),
        .ADDR_W (IDX_W)
    ) u_stack (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (IDX_W'(top_reg - TOP_W'(1))),
        .rd_data (stk_rd_data),
        .wr_en   (stk_wr_en),
        .wr_addr (IDX_W'(top_reg)),
        .wr_data (page_reg)
    );

    rcpa_count_mem #(
        .DEPTH  (NUM_PAGES),
        .ADDR_W (IDX_W),
        .DATA_W (COUNT_WIDTH)
    ) u_count (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear_busy (clear_busy),
        .rd_en      (accept),
        .rd_addr    (IDX_W'(page)),
        .rd_data    (cnt_rd_data),
        .wr_en      (cnt_wr_en),
        .wr_addr    (cnt_wr_addr),
        .wr_data    (cnt_wr_data)
    );

    // ---- control and execute ----
    // Writes land at the end of the execute cycle, and the next read is
    // issued no earlier than the following edge, so no forwarding is needed.
    always_comb
    begin
        logic                   slot_free;
        logic                   in_range;
        logic                   can_push;
        logic [COUNT_WIDTH-1:0] cnt_dec;
        logic [COUNT_WIDTH-1:0] cnt_inc;

        slot_free = !out_valid_reg || out_ready;
        in_range  = (page_reg >= lowest_page_reg) && (32'(page_reg) < NUM_PAGES);
        can_push  = 32'(top_reg) < NUM_PAGES;
        cnt_dec   = cnt_rd_data - COUNT_WIDTH'(1);
        cnt_inc   = cnt_rd_data + COUNT_WIDTH'(1);

        state_next      = state_reg;
        top_next        = top_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        alloc_page_next = alloc_page_reg;
        ref_count_next  = ref_count_reg;
        page_freed_next = page_freed_reg;
        free_pages_next = free_pages_reg;
        stk_wr_en       = 1'b0;
        cnt_wr_en       = 1'b0;
        cnt_wr_addr     = IDX_W'(page_reg);
        cnt_wr_data     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (slot_free)
                begin
                    state_next      = ST_IDLE;
                    out_valid_next  = 1'b1;
                    status_next     = STAT_OK;
                    alloc_page_next = '0;
                    ref_count_next  = '0;
                    page_freed_next = 1'b0;
                    if (func_reg == FUNC_ALLOC)
                    begin
                        if (top_reg == '0)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            top_next        = top_reg - TOP_W'(1);
                            alloc_page_next = stk_rd_data;
                            ref_count_next  = COUNT_W'(1);
                            cnt_wr_en       = 1'b1;
                            cnt_wr_addr     = IDX_W'(stk_rd_data);
                            cnt_wr_data     = COUNT_WIDTH'(1);
                        end
                    end
                    else if (func_reg <= FUNC_DONATE)
                    begin
                        if (!in_range)
                        begin
                            status_next = STAT_RANGE;
                        end
                        else
                        begin
                            case (func_reg)
                                FUNC_RELEASE:
                                begin
                                    if (cnt_rd_data == '0)
                                    begin
                                        status_next = STAT_ZERO;
                                    end
                                    else
                                    begin
                                        cnt_wr_en      = 1'b1;
                                        cnt_wr_data    = cnt_dec;
                                        ref_count_next = COUNT_W'(cnt_dec);
                                        // last reference gone: page returns if the stack has room
                                        if ((cnt_dec == '0) && can_push)
                                        begin
                                            stk_wr_en       = 1'b1;
                                            top_next        = top_reg + TOP_W'(1);
                                            page_freed_next = 1'b1;
                                        end
                                    end
                                end
                                FUNC_ADD:
                                begin
                                    if (cnt_rd_data == '1)
                                    begin
                                        status_next    = STAT_SAT;
                                        ref_count_next = COUNT_W'(cnt_rd_data);
                                    end
                                    else
                                    begin
                                        cnt_wr_en      = 1'b1;
                                        cnt_wr_data    = cnt_inc;
                                        ref_count_next = COUNT_W'(cnt_inc);
                                    end
                                end
                                FUNC_QUERY:
                                begin
                                    ref_count_next = COUNT_W'(cnt_rd_data);
                                end
                                FUNC_DONATE:
                                begin
                                    // count cleared even when the push is dropped
                                    cnt_wr_en = 1'b1;
                                    if (can_push)
                                    begin
                                        stk_wr_en       = 1'b1;
                                        top_next        = top_reg + TOP_W'(1);
                                        page_freed_next = 1'b1;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                    free_pages_next = FREE_W'(top_next);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            page_reg <= page;
        end
        status_reg     <= status_next;
        alloc_page_reg <= alloc_page_next;
        ref_count_reg  <= ref_count_next;
        page_freed_reg <= page_freed_next;
        free_pages_reg <= free_pages_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign alloc_page = alloc_page_reg;
    assign ref_count  = ref_count_reg;
    assign page_freed = page_freed_reg;
    assign free_pages = free_pages_reg;

endmodule

`default_nettype wire

// ===== rtl/rcpa_checker.sv =====
// Port-level assertions for the page allocator, bound to the top level.
`default_nettype none

module rcpa_checker
    import rcpa_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire logic [STATUS_W-1:0] status,
    input wire logic [PAGE_W-1:0]   alloc_page,
    input wire logic [COUNT_W-1:0]  ref_count,
    input wire logic                page_freed,
    input wire logic [FREE_W-1:0]   free_pages
);

    // one request at a time: ready drops right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("in_ready high in the cycle after an accept");

    // a stalled response holds its status, ref_count and free_pages fields
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(ref_count)
            && $stable(free_pages))
    else $error("stalled response changed");

    // failed allocate only when the stack is empty, and it hands out nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_EMPTY) |->
            (free_pages == '0) && (alloc_page == '0) && (ref_count == '0))
    else $error("empty-stack response inconsistent");

    // a push leaves a zero count and a non-empty stack
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && page_freed |->
            (status == STAT_OK) && (ref_count == '0) && (free_pages != '0))
    else $error("freed page response inconsistent");

endmodule

bind refcounted_page_allocator_core rcpa_checker u_rcpa_checker (.*);

`default_nettype wire
